FILE: src/pks_pkg.sv
package pks_pkg;

    localparam int TIMER_BITS = 16;
    localparam int CFG_INDEX_BITS = 4;
    localparam int BLINK_BITS = 4;

    typedef logic [TIMER_BITS-1:0] timer_t;
    typedef logic [BLINK_BITS-1:0] blink_t;

    localparam timer_t TIMER_MAX = {TIMER_BITS{1'b1}};
    localparam timer_t POWERDOWN_PULSE = TIMER_BITS'(500);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_KILL_MIN_HOLD    = 4'd0,
        CFG_KILL_TIMEOUT     = 4'd1,
        CFG_EDGE_DEBOUNCE    = 4'd2,
        CFG_HIGH_BEFORE_EDGE = 4'd3,
        CFG_INHIBIT_MAX      = 4'd4,
        CFG_BLINK_COUNT      = 4'd5,
        CFG_BLINK_ON_TIME    = 4'd6,
        CFG_BLINK_OFF_TIME   = 4'd7
    } cfg_index_t;

    typedef struct packed {
        timer_t kill_min_hold;
        timer_t kill_timeout;
        timer_t edge_debounce;
        timer_t high_before_edge;
        timer_t inhibit_max;
        blink_t blink_count;
        timer_t blink_on_time;
        timer_t blink_off_time;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        kill_min_hold:    TIMER_BITS'(10),
        kill_timeout:     TIMER_BITS'(1000),
        edge_debounce:    TIMER_BITS'(10),
        high_before_edge: TIMER_BITS'(10),
        inhibit_max:      TIMER_BITS'(1000),
        blink_count:      BLINK_BITS'(3),
        blink_on_time:    TIMER_BITS'(120),
        blink_off_time:   TIMER_BITS'(120)
    };

    typedef enum logic [1:0] {
        LED_IDLE      = 2'd0,
        LED_BLINK_ON  = 2'd1,
        LED_BLINK_OFF = 2'd2,
        LED_LONG      = 2'd3
    } led_phase_t;

    typedef struct packed {
        logic rise;
        logic fall;
    } pg_edge_t;

    function automatic timer_t sat_inc(input timer_t x);
        return (x == TIMER_MAX) ? TIMER_MAX : x + timer_t'(1);
    endfunction

endpackage

FILE: src/pks_cfg.sv
module pks_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pks_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [pks_pkg::TIMER_BITS-1:0]      cfg_data,
    output pks_pkg::cfg_t                       cfg
);
    import pks_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_KILL_MIN_HOLD:    cfg_next.kill_min_hold = cfg_data;
                CFG_KILL_TIMEOUT:     cfg_next.kill_timeout = cfg_data;
                CFG_EDGE_DEBOUNCE:    cfg_next.edge_debounce = cfg_data;
                CFG_HIGH_BEFORE_EDGE: cfg_next.high_before_edge = cfg_data;
                CFG_INHIBIT_MAX:      cfg_next.inhibit_max = cfg_data;
                CFG_BLINK_COUNT:      cfg_next.blink_count = cfg_data[BLINK_BITS-1:0];
                CFG_BLINK_ON_TIME:    cfg_next.blink_on_time = cfg_data;
                CFG_BLINK_OFF_TIME:   cfg_next.blink_off_time = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: src/pks_kill.sv
module pks_kill (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              power_good,
    input  logic              int_level,
    input  pks_pkg::cfg_t     cfg,
    output pks_pkg::pg_edge_t pg_edge,
    output logic              kill_next,
    output logic              inhibit_next
);
    import pks_pkg::*;

    logic   prev_pg_reg, prev_pg_next;
    logic   prev_il_reg, prev_il_next;
    logic   high_valid_reg, high_valid_next;
    timer_t high_time_reg, high_time_next;
    logic   inhibit_flag_reg, inhibit_flag_next;
    timer_t inhibit_time_reg, inhibit_time_next;
    timer_t since_edge_reg, since_edge_next;
    logic   kill_active_reg, kill_active_next;
    timer_t kill_time_reg, kill_time_next;

    logic   inh_set;
    logic   kill_set;
    logic   edge_ok;
    timer_t since_inc;
    timer_t kill_time_run;

    assign pg_edge.rise = power_good & ~prev_pg_reg;
    assign pg_edge.fall = ~power_good & prev_pg_reg;

    always_comb
    begin
        high_valid_next = pg_edge.rise ? 1'b1 : (pg_edge.fall ? 1'b0 : high_valid_reg);
        if (pg_edge.rise || pg_edge.fall)
            high_time_next = '0;
        else
            high_time_next = high_valid_reg ? sat_inc(high_time_reg) : high_time_reg;

        inh_set = pg_edge.rise | inhibit_flag_reg;
        if (pg_edge.rise)
            inhibit_time_next = '0;
        else
            inhibit_time_next = inhibit_flag_reg ? sat_inc(inhibit_time_reg)
                                                 : inhibit_time_reg;
        inhibit_flag_next = inh_set && power_good &&
                            (inhibit_time_next < cfg.inhibit_max);

        since_inc = sat_inc(since_edge_reg);
        edge_ok = prev_il_reg && !int_level && (since_inc >= cfg.edge_debounce);
        since_edge_next = edge_ok ? '0 : since_inc;

        kill_time_run = kill_active_reg ? sat_inc(kill_time_reg) : kill_time_reg;
        kill_set = edge_ok && high_valid_next &&
                   (high_time_next >= cfg.high_before_edge) &&
                   !inhibit_flag_next && !kill_active_reg;
        kill_time_next = kill_set ? '0 : kill_time_run;
        kill_active_next = (kill_set || kill_active_reg) &&
                           !((!power_good && kill_time_next >= cfg.kill_min_hold) ||
                             (kill_time_next >= cfg.kill_timeout));

        prev_pg_next = power_good;
        prev_il_next = int_level;
    end

    assign kill_next = kill_active_next;
    assign inhibit_next = inhibit_flag_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pg_reg      <= 1'b0;
            prev_il_reg      <= 1'b1;
            high_valid_reg   <= 1'b0;
            high_time_reg    <= '0;
            inhibit_flag_reg <= 1'b0;
            inhibit_time_reg <= '0;
            since_edge_reg   <= '0;
            kill_active_reg  <= 1'b0;
            kill_time_reg    <= '0;
        end
        else if (accept)
        begin
            prev_pg_reg      <= prev_pg_next;
            prev_il_reg      <= prev_il_next;
            high_valid_reg   <= high_valid_next;
            high_time_reg    <= high_time_next;
            inhibit_flag_reg <= inhibit_flag_next;
            inhibit_time_reg <= inhibit_time_next;
            since_edge_reg   <= since_edge_next;
            kill_active_reg  <= kill_active_next;
            kill_time_reg    <= kill_time_next;
        end
    end

    a_kill_not_inhibited: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(kill_active_reg) |-> !inhibit_flag_reg)
        else $error("kill asserted while inhibit in force");

    a_kill_needs_high: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(kill_active_reg) |-> high_valid_reg)
        else $error("kill asserted without power-good high");

    a_inhibit_needs_pg: assert property (@(posedge clk) disable iff (!rst_n)
        inhibit_flag_reg |-> prev_pg_reg)
        else $error("inhibit held with power-good low");

    a_high_valid_tracks_pg: assert property (@(posedge clk) disable iff (!rst_n)
        high_valid_reg == prev_pg_reg)
        else $error("high timer validity out of step with power-good");

endmodule

FILE: src/pks_led.sv
module pks_led (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  pks_pkg::pg_edge_t pg_edge,
    input  pks_pkg::cfg_t     cfg,
    output logic              led_on
);
    import pks_pkg::*;

    led_phase_t phase_reg, phase_next;
    timer_t     timer_reg, timer_next;
    blink_t     blinks_reg, blinks_next;

    led_phase_t phase_cur;
    timer_t     timer_cur;
    blink_t     blinks_cur;
    timer_t     timer_inc;

    // a power-good edge restarts the pattern within the same tick
    always_comb
    begin
        phase_cur  = phase_reg;
        timer_cur  = timer_reg;
        blinks_cur = blinks_reg;
        if (pg_edge.rise)
        begin
            timer_cur = '0;
            if (cfg.blink_count != '0)
            begin
                phase_cur  = LED_BLINK_ON;
                blinks_cur = cfg.blink_count;
            end
            else
            begin
                phase_cur  = LED_IDLE;
                blinks_cur = '0;
            end
        end
        else if (pg_edge.fall)
        begin
            phase_cur  = LED_LONG;
            timer_cur  = '0;
            blinks_cur = '0;
        end
    end

    always_comb
    begin
        timer_inc   = sat_inc(timer_cur);
        phase_next  = phase_cur;
        timer_next  = timer_inc;
        blinks_next = blinks_cur;
        unique case (phase_cur)
            LED_BLINK_ON:
            begin
                if (timer_inc >= cfg.blink_on_time)
                begin
                    timer_next = '0;
                    if (blinks_cur <= blink_t'(1))
                    begin
                        blinks_next = '0;
                        phase_next  = LED_IDLE;
                    end
                    else
                    begin
                        blinks_next = blinks_cur - blink_t'(1);
                        phase_next  = LED_BLINK_OFF;
                    end
                end
            end
            LED_BLINK_OFF:
            begin
                if (timer_inc >= cfg.blink_off_time)
                begin
                    timer_next = '0;
                    phase_next = LED_BLINK_ON;
                end
            end
            LED_LONG:
            begin
                if (timer_inc >= POWERDOWN_PULSE)
                begin
                    timer_next = '0;
                    phase_next = LED_IDLE;
                end
            end
            default:
            begin
                timer_next = '0;
                phase_next = LED_IDLE;
            end
        endcase
    end

    always_comb
    begin
        unique case (phase_cur) inside
            LED_BLINK_ON, LED_LONG: led_on = 1'b1;
            default:                led_on = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= LED_IDLE;
            timer_reg  <= '0;
            blinks_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            timer_reg  <= timer_next;
            blinks_reg <= blinks_next;
        end
    end

endmodule

FILE: src/power_kill_sequencer.sv
// Power kill sequencer. Each request on the s_ stream is one millisecond tick with the
// sampled power-good and interrupt levels; each tick yields exactly one response on the
// m_ stream: kill and inhibit levels at the end of that tick, the LED level within it.
// A tick is taken every clock cycle: the whole tick update is one pass of logic from the
// state registers into the output register, which the sink may stall. The config channel
// (index 0..7, 16-bit data, always ready) must be written only between ticks (unenforced).
module power_kill_sequencer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [0] power_good, [1] int_level
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [0] kill_drive, [1] led_on,
                                                           // [2] inhibit_active
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pks_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [pks_pkg::TIMER_BITS-1:0]      cfg_data
);
    import pks_pkg::*;

    cfg_t     cfg;
    pg_edge_t pg_edge;
    logic     accept;
    logic     kill_next;
    logic     inhibit_next;
    logic     led_on;

    logic       out_valid_reg, out_valid_next;
    logic [2:0] out_data_reg, out_data_next;

    assign s_tready = ~out_valid_reg | m_tready;
    assign accept   = s_tvalid & s_tready;

    pks_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pks_kill u_kill (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .power_good   (s_tdata[0]),
        .int_level    (s_tdata[1]),
        .cfg          (cfg),
        .pg_edge      (pg_edge),
        .kill_next    (kill_next),
        .inhibit_next (inhibit_next)
    );

    pks_led u_led (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .pg_edge (pg_edge),
        .cfg     (cfg),
        .led_on  (led_on)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg & ~m_tready;
        out_data_next  = out_data_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {inhibit_next, led_on, kill_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_data_reg};

endmodule
